// ===== rtl/core/uvst_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the unique value set table.
package uvst_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CFG_W       = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_READ,
		OP_WRITE
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_DUP,
		ST_FULL,
		ST_RANGE
	} status_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_FETCH,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] read_data;
		logic [CNT_W-1:0]       entry_count;
		logic [CNT_W-1:0]       removed_count;
		status_t                status;
	} res_t;

endpackage

// ===== rtl/core/uvst_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the unique value set table.
interface uvst_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             op;
	logic [uvst_pkg::IDX_W-1:0]             index;
	logic signed [uvst_pkg::VALUE_WIDTH-1:0] value;

	modport source (output valid, output op, output index, output value, input ready);
	modport sink (input valid, input op, input index, input value, output ready);
endinterface

interface uvst_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [uvst_pkg::VALUE_WIDTH-1:0] read_data;
	logic [uvst_pkg::CNT_W-1:0]             entry_count;
	logic [uvst_pkg::CNT_W-1:0]             removed_count;
	logic [1:0]                             status;

	modport source (output valid, output read_data, output entry_count,
		output removed_count, output status, input ready);
	modport sink (input valid, input read_data, input entry_count,
		input removed_count, input status, output ready);
endinterface

// ===== rtl/core/uvst_mem.sv =====
`timescale 1ns / 1ps
// Entry store: one write port, one read port with registered read data.
module uvst_mem (
	input  logic                             clk,
	input  logic                             we,
	input  logic [uvst_pkg::IDX_W-1:0]       waddr,
	input  logic [uvst_pkg::VALUE_WIDTH-1:0] wdata,
	input  logic                             re,
	input  logic [uvst_pkg::IDX_W-1:0]       raddr,
	output logic [uvst_pkg::VALUE_WIDTH-1:0] rdata
);

	logic [uvst_pkg::VALUE_WIDTH-1:0] mem_q [uvst_pkg::CAPACITY];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read word; hold it between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/uvst_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: walks the entry store one word a cycle through a shared comparator.
module uvst_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [1:0]                       op,
	input  logic [uvst_pkg::IDX_W-1:0]       idx,
	input  logic [uvst_pkg::VALUE_WIDTH-1:0] val,
	input  logic [uvst_pkg::CNT_W-1:0]       eff_lim,
	input  logic                             out_free,
	output logic                             idle,
	output uvst_pkg::res_t                   res
);

	uvst_pkg::seq_state_t             state_q, state_d;
	uvst_pkg::op_t                    op_q, op_d;
	uvst_pkg::status_t                status_q, status_d;
	logic [uvst_pkg::IDX_W-1:0]       idx_q, idx_d;
	logic [uvst_pkg::VALUE_WIDTH-1:0] val_q, val_d;
	logic [uvst_pkg::CNT_W-1:0]       count_q, count_d;
	logic [uvst_pkg::CNT_W-1:0]       rd_ptr_q, rd_ptr_d;
	logic [uvst_pkg::CNT_W-1:0]       wr_ptr_q, wr_ptr_d;
	logic [uvst_pkg::CNT_W-1:0]       rem_q, rem_d;
	logic                             found_q, found_d;
	logic                             cmp_vld_q, cmp_vld_d;

	logic                             mem_we, mem_re;
	logic [uvst_pkg::IDX_W-1:0]       mem_waddr, mem_raddr;
	logic [uvst_pkg::VALUE_WIDTH-1:0] mem_wdata, mem_rdata;
	logic                             eq, rd_more, scan_done, in_range;

	uvst_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Shared comparator and scan bounds
	assign eq        = cmp_vld_q && (mem_rdata == val_q);
	assign rd_more   = rd_ptr_q < count_q;
	assign scan_done = (state_q == uvst_pkg::SQ_SCAN) && !rd_more && !cmp_vld_q;
	assign in_range  = {1'b0, idx_q} < count_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= uvst_pkg::SQ_IDLE;
			count_q   <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			cmp_vld_q <= cmp_vld_d;
		end
	end

	// Working registers of the item in flight
	always_ff @(posedge clk) begin
		op_q     <= op_d;
		status_q <= status_d;
		idx_q    <= idx_d;
		val_q    <= val_d;
		rd_ptr_q <= rd_ptr_d;
		wr_ptr_q <= wr_ptr_d;
		rem_q    <= rem_d;
		found_q  <= found_d;
	end

	// Next state, store access and pointer updates
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		status_d  = status_q;
		idx_d     = idx_q;
		val_d     = val_q;
		count_d   = count_q;
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		rem_d     = rem_q;
		found_d   = found_q;
		cmp_vld_d = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q[uvst_pkg::IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q[uvst_pkg::IDX_W-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			uvst_pkg::SQ_IDLE: begin
				if (start) begin
					op_d     = uvst_pkg::op_t'(op);
					idx_d    = idx;
					val_d    = val;
					status_d = uvst_pkg::ST_OK;
					rd_ptr_d = '0;
					wr_ptr_d = '0;
					rem_d    = '0;
					found_d  = 1'b0;
					if (op == uvst_pkg::OP_INSERT || op == uvst_pkg::OP_REMOVE) begin
						state_d = uvst_pkg::SQ_SCAN;
					end else begin
						state_d = uvst_pkg::SQ_FETCH;
					end
				end
			end
			uvst_pkg::SQ_SCAN: begin
				// Issue the next read while comparing the previous word
				if (rd_more) begin
					mem_re   = 1'b1;
					rd_ptr_d = rd_ptr_q + 1'b1;
				end
				cmp_vld_d = rd_more;
				if (cmp_vld_q) begin
					if (op_q == uvst_pkg::OP_INSERT) begin
						found_d = found_q | eq;
					end else if (eq) begin
						rem_d = rem_q + 1'b1;
					end else begin
						// Compact: move the survivor down to the write pointer
						mem_we   = 1'b1;
						wr_ptr_d = wr_ptr_q + 1'b1;
					end
				end
				if (scan_done) begin
					state_d = uvst_pkg::SQ_DONE;
					if (op_q == uvst_pkg::OP_REMOVE) begin
						count_d = wr_ptr_q;
					end else if (found_q) begin
						status_d = uvst_pkg::ST_DUP;
					end else if (count_q >= eff_lim) begin
						status_d = uvst_pkg::ST_FULL;
					end else begin
						// Append the new value at the tail
						mem_we    = 1'b1;
						mem_waddr = count_q[uvst_pkg::IDX_W-1:0];
						mem_wdata = val_q;
						count_d   = count_q + 1'b1;
					end
				end
			end
			uvst_pkg::SQ_FETCH: begin
				state_d = uvst_pkg::SQ_DONE;
				if (!in_range) begin
					status_d = uvst_pkg::ST_RANGE;
				end else if (op_q == uvst_pkg::OP_READ) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = val_q;
				end
			end
			uvst_pkg::SQ_DONE: begin
				// Hold the result until the output register can take it
				if (out_free) begin
					state_d = uvst_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = uvst_pkg::SQ_IDLE;
			end
		endcase
	end

	// Result beat
	assign idle              = state_q == uvst_pkg::SQ_IDLE;
	assign res.done          = state_q == uvst_pkg::SQ_DONE;
	assign res.read_data     = (op_q == uvst_pkg::OP_READ && status_q == uvst_pkg::ST_OK) ?
		mem_rdata : '0;
	assign res.entry_count   = count_q;
	assign res.removed_count = (op_q == uvst_pkg::OP_REMOVE) ? rem_q : '0;
	assign res.status        = status_q;

	// Count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= uvst_pkg::CNT_W'(uvst_pkg::CAPACITY))
		else $error("entry count above capacity");

	// Compaction writes only behind the read pointer
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == uvst_pkg::SQ_SCAN && mem_we && !scan_done) |-> (wr_ptr_q < rd_ptr_q))
		else $error("compaction write overtakes the read pointer");

	// Removed plus kept entries equal the old count
	a_remove_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_done && op_q == uvst_pkg::OP_REMOVE) |->
		({1'b0, rem_q} + {1'b0, wr_ptr_q} == {1'b0, count_q}))
		else $error("remove lost or invented entries");

	// An insert grows the table by at most one
	a_insert_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_done && op_q == uvst_pkg::OP_INSERT) |=>
		({1'b0, count_q} <= {1'b0, $past(count_q)} + 1'b1))
		else $error("insert grew the table by more than one");

endmodule

// ===== rtl/core/unique_value_set_table.sv =====
`timescale 1ns / 1ps
// Top level of the unique value set table.
//
// Usage:
//   req carries one operation per beat (op, index, value): insert, remove all
//   equal, read by index, write by index. rsp returns one beat per request with
//   read_data, entry_count, removed_count and status.
//   cfg_we/cfg_wdata write capacity_limit; write it only while the table idles.
// Operation:
//   Insert and remove scan the entry store one word a cycle through a single
//   comparator; read and write by index go straight to a single store access.
//   One request is in work at a time; req.ready is high only while the
//   sequencer idles, so a new request is taken only once the last has finished.
// Stall:
//   The result sits in an output register; the sequencer may take the next
//   request while it waits, and holds its own result if the register is full.
// Reset:
//   arst_n empties the table and sets capacity_limit to 16. Entry contents are
//   not cleared; only positions below the count are ever read.
module unique_value_set_table (
	input  logic                       clk,
	input  logic                       arst_n,
	uvst_req_if.sink                   req,
	uvst_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [uvst_pkg::CFG_W-1:0] cfg_wdata
);

	logic [uvst_pkg::CFG_W-1:0]       limit_q;
	logic [uvst_pkg::CNT_W-1:0]       eff_lim;
	logic                             idle, out_free, out_vld_q;
	uvst_pkg::res_t                   res;
	logic [uvst_pkg::VALUE_WIDTH-1:0] rdata_q;
	logic [uvst_pkg::CNT_W-1:0]       cnt_q, rem_q;
	uvst_pkg::status_t                status_q;

	// Capacity limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= uvst_pkg::CFG_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Saturate the limit at the store depth
	assign eff_lim = ({1'b0, limit_q} > (uvst_pkg::CFG_W + 1)'(uvst_pkg::CAPACITY)) ?
		uvst_pkg::CNT_W'(uvst_pkg::CAPACITY) : uvst_pkg::CNT_W'(limit_q);

	uvst_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req.valid && idle),
		.op       (req.op),
		.idx      (req.index),
		.val      (req.value),
		.eff_lim  (eff_lim),
		.out_free (out_free),
		.idle     (idle),
		.res      (res)
	);

	assign req.ready = idle;
	assign out_free  = !out_vld_q || rsp.ready;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= res.done;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_free && res.done) begin
			rdata_q  <= res.read_data;
			cnt_q    <= res.entry_count;
			rem_q    <= res.removed_count;
			status_q <= res.status;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.read_data     = rdata_q;
	assign rsp.entry_count   = cnt_q;
	assign rsp.removed_count = rem_q;
	assign rsp.status        = status_q;

endmodule

// ===== tb/sv/uvst_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the unique value set table: tracks the table contents and checks replies.
module uvst_table_checker
	import uvst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	uvst_req_if              req,
	uvst_rsp_if              rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int unsigned      fail_count,
	output int unsigned      outstanding
);

	localparam int SHOWN_MAX = 10;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] read_data;
		logic [CNT_W-1:0]       entry_count;
		logic [CNT_W-1:0]       removed_count;
		status_t                status;
	} table_reply_t;

	// Table contents as the block should hold them
	logic [VALUE_WIDTH-1:0] held_vals [CAPACITY];
	int unsigned            held_count;
	logic [CFG_W-1:0]       capacity_limit;

	table_reply_t expected_replies [$];
	int unsigned  errors;

	// Apply one operation to the table copy and return the reply it should give
	function automatic table_reply_t apply_request(op_t op, logic [IDX_W-1:0] idx,
			logic [VALUE_WIDTH-1:0] v);
		table_reply_t reply;
		int unsigned  lim;
		int unsigned  keep;
		bit           found;
		reply.read_data     = '0;
		reply.removed_count = '0;
		reply.status        = ST_OK;
		lim   = (capacity_limit > CAPACITY) ? CAPACITY : capacity_limit;
		found = 1'b0;
		keep  = 0;
		case (op)
			OP_INSERT: begin
				for (int i = 0; i < held_count; i++)
					if (held_vals[i] == v)
						found = 1'b1;
				// duplicate wins over full
				if (found)
					reply.status = ST_DUP;
				else if (held_count >= lim)
					reply.status = ST_FULL;
				else begin
					held_vals[held_count] = v;
					held_count++;
				end
			end
			OP_REMOVE: begin
				// drop every match and close the gaps in order
				for (int i = 0; i < held_count; i++) begin
					if (held_vals[i] == v)
						reply.removed_count++;
					else begin
						held_vals[keep] = held_vals[i];
						keep++;
					end
				end
				held_count = keep;
			end
			OP_READ: begin
				if (idx < held_count)
					reply.read_data = held_vals[idx];
				else
					reply.status = ST_RANGE;
			end
			default: begin
				if (idx < held_count)
					held_vals[idx] = v;
				else
					reply.status = ST_RANGE;
			end
		endcase
		reply.entry_count = CNT_W'(held_count);
		return reply;
	endfunction

	// Predict on each request beat, compare on each reply beat
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		table_reply_t got;
		if (!arst_n) begin
			held_count     = 0;
			capacity_limit = CFG_RESET;
			expected_replies.delete();
			errors         = 0;
			fail_count     <= 0;
			outstanding    <= 0;
		end else begin
			if (cfg_we)
				capacity_limit = cfg_wdata;
			if (req.valid && req.ready)
				expected_replies.push_back(apply_request(op_t'(req.op), req.index,
					req.value));
			if (rsp.valid && rsp.ready) begin
				got.read_data     = rsp.read_data;
				got.entry_count   = rsp.entry_count;
				got.removed_count = rsp.removed_count;
				got.status        = status_t'(rsp.status);
				if (expected_replies.size() == 0) begin
					if (errors < SHOWN_MAX)
						$display("%0t: reply beat with nothing pending: %s",
							$realtime, $sformatf("rd=%0d cnt=%0d rm=%0d st=%0d",
							$signed(got.read_data), got.entry_count,
							got.removed_count, got.status));
					errors++;
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						if (errors < SHOWN_MAX)
							$display("%0t: reply mismatch: want %s, got %s", $realtime,
								$sformatf("rd=%0d cnt=%0d rm=%0d st=%0d",
								$signed(want.read_data), want.entry_count,
								want.removed_count, want.status),
								$sformatf("rd=%0d cnt=%0d rm=%0d st=%0d",
								$signed(got.read_data), got.entry_count,
								got.removed_count, got.status));
						errors++;
					end
				end
			end
			outstanding <= expected_replies.size();
			fail_count  <= errors;
		end
	end

endmodule

// ===== tb/sv/unique_value_set_table_test.sv =====
`timescale 1ns / 1ps
// Top of the unique value set table testbench: clock, reset, stimulus and verdict.
module unique_value_set_table_test;
	import uvst_pkg::*;

	localparam int MAX_GAP     = 18;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 90;
	localparam int STALL_LIMIT = 2000;
	localparam int POOL_SIZE   = 24;
	localparam int N_PHASES    = 8;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	int unsigned      fail_count;
	int unsigned      outstanding;
	int unsigned      idle_cycles;
	bit               no_gaps;
	bit               long_hold;

	logic [VALUE_WIDTH-1:0] value_pool [POOL_SIZE];

	// Per phase: limit (negative draws one), item count, insert and remove weights in percent
	int phase_limit  [N_PHASES] = '{3, 16, 5, 0, 31, 1, -1, 16};
	int phase_items  [N_PHASES] = '{0, 200, 150, 60, 200, 100, 140, 100};
	int phase_insert [N_PHASES] = '{0, 60, 40, 40, 60, 35, 45, 40};
	int phase_remove [N_PHASES] = '{0, 10, 25, 20, 10, 25, 20, 20};

	uvst_req_if req_ch ();
	uvst_rsp_if rsp_ch ();

	unique_value_set_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	uvst_table_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stop offering and hold until every reply has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_limit(logic [CFG_W-1:0] lim);
		wait_drained();
		cfg_wdata <= lim;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Offer one request beat after a random gap and hold it until accepted
	task automatic send_op(op_t op, logic [IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] v);
		int gap;
		gap = (no_gaps || long_hold) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.index <= idx;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_random(int ins_w, int rem_w, int lim);
		int                     roll;
		int                     hi;
		op_t                    op;
		logic [IDX_W-1:0]       idx;
		logic [VALUE_WIDTH-1:0] v;
		roll = $urandom_range(0, 99);
		if (roll < ins_w)
			op = OP_INSERT;
		else if (roll < ins_w + rem_w)
			op = OP_REMOVE;
		else if (roll[0])
			op = OP_READ;
		else
			op = OP_WRITE;
		// aim most indexes below the limit, the rest anywhere
		hi  = (lim == 0) ? 0 : ((lim > CAPACITY) ? CAPACITY - 1 : lim - 1);
		idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, CAPACITY - 1)) :
			IDX_W'($urandom_range(0, hi));
		v   = ($urandom_range(0, 4) == 0) ? $urandom : value_pool[$urandom_range(0, POOL_SIZE - 1)];
		send_op(op, idx, v);
	endtask

	// Count cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Reply side: random stalls, one long hold-off to back the block up
	initial begin
		int          gap;
		int unsigned beats;
		rsp_ch.ready <= 1'b0;
		beats = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (beats == HOLD_AT) begin
				long_hold = 1'b1;
				gap       = HOLD_CYCLES;
			end else
				gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			long_hold = 1'b0;
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			beats++;
		end
	end

	initial begin
		int lim;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= CFG_RESET;
		req_ch.valid <= 1'b0;
		req_ch.op    <= OP_INSERT;
		req_ch.index <= '0;
		req_ch.value <= '0;
		no_gaps   = 1'b0;
		long_hold = 1'b0;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, duplicates, full table, range errors, duplicate write
		set_limit(CFG_W'(3));
		send_op(OP_INSERT, 4'd0, 32'h8000_0000);
		send_op(OP_INSERT, 4'd15, 32'h7FFF_FFFF);
		send_op(OP_INSERT, 4'd7, 32'h7FFF_FFFF);
		send_op(OP_INSERT, 4'd3, 32'h0000_0000);
		send_op(OP_INSERT, 4'd9, 32'hFFFF_FFFF);
		send_op(OP_INSERT, 4'd1, 32'h8000_0000);
		send_op(OP_READ, 4'd0, 32'hFFFF_FFFF);
		send_op(OP_READ, 4'd2, 32'h1234_5678);
		send_op(OP_READ, 4'd3, 32'h0000_0000);
		send_op(OP_READ, 4'd15, 32'h8000_0000);
		send_op(OP_WRITE, 4'd1, 32'h8000_0000);
		send_op(OP_READ, 4'd1, 32'h0000_0000);
		send_op(OP_REMOVE, 4'd6, 32'h8000_0000);
		send_op(OP_REMOVE, 4'd0, 32'h0000_3039);
		send_op(OP_WRITE, 4'd5, 32'hFFFF_FFFF);
		send_op(OP_WRITE, 4'd0, 32'h5A5A_A5A5);
		send_op(OP_READ, 4'd0, 32'h0000_0000);
		send_op(OP_REMOVE, 4'd12, 32'h5A5A_A5A5);
		send_op(OP_READ, 4'd0, 32'h7FFF_FFFF);
		send_op(OP_WRITE, 4'd15, 32'h7FFF_FFFF);
		send_op(OP_INSERT, 4'd15, 32'hFFFF_FFFF);

		// Random phases: fill at full size, then lower, zero, oversize, small and random limits, then full size again
		for (int p = 1; p < N_PHASES; p++) begin
			for (int i = 0; i < 6; i++)
				value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
			no_gaps = (p == 5) || ($urandom_range(0, 3) == 0);
			lim = (phase_limit[p] < 0) ? $urandom_range(2, CAPACITY - 1) : phase_limit[p];
			set_limit(CFG_W'(lim));
			repeat (phase_items[p])
				send_random(phase_insert[p], phase_remove[p], lim);
		end
		no_gaps = 1'b0;

		wait_drained();
		repeat (CAPACITY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/uvst_pkg.sv
rtl/core/uvst_if.sv
rtl/core/uvst_mem.sv
rtl/core/uvst_seq.sv
rtl/core/unique_value_set_table.sv
tb/sv/uvst_table_checker.sv
tb/sv/unique_value_set_table_test.sv
